FILE: design/sss_pkg.sv
// ============================================================================
// sss_pkg
// Shared sizes, codes and item types for the stride slice scheduler.
// ============================================================================
package sss_pkg;

    // Table and field sizes.
    localparam int MAX_ENTRIES   = 16;
    localparam int TICKET_BITS   = 10;
    localparam int DURATION_BITS = 16;
    localparam int ENTRY_BITS    = $clog2(MAX_ENTRIES);
    localparam int COUNT_BITS    = $clog2(MAX_ENTRIES + 1);
    localparam int INDEX_BITS    = 4;
    localparam int SLICE_BITS    = 16;
    localparam int PCOUNT_BITS   = 5;
    localparam int CLOCK_BITS    = 20;
    localparam int STRIDE_BITS   = 32;
    localparam int PASS_BITS     = 48;
    localparam int MULT_BITS     = 32;
    localparam int DIV_BITS      = MULT_BITS + TICKET_BITS;

    // Register reset values.
    localparam logic [SLICE_BITS-1:0]  DEFAULT_SLICE = 16'd10;
    localparam logic [PCOUNT_BITS-1:0] DEFAULT_COUNT = 5'd1;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TIME_SLICE    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PROCESS_COUNT = 1'd1;

    // Item modes; the last code is unused and the item is ignored.
    localparam logic [1:0] MODE_LOAD     = 2'd0;
    localparam logic [1:0] MODE_COMPUTE  = 2'd1;
    localparam logic [1:0] MODE_SCHEDULE = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO     = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
    localparam logic [1:0] STATUS_ALL_DONE = 2'd3;

    typedef struct packed {
        logic [1:0]               mode;
        logic [INDEX_BITS-1:0]    entry_index;
        logic [TICKET_BITS-1:0]   tickets;
        logic [DURATION_BITS-1:0] duration;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [INDEX_BITS-1:0] chosen;
        logic [CLOCK_BITS-1:0] start_time;
        logic [CLOCK_BITS-1:0] end_time;
        logic                  first_run;
        logic                  finished;
        logic                  all_done;
        logic [MULT_BITS-1:0]  common_multiple;
    } out_item_t;

    // One table row as held in the entry memory.
    typedef struct packed {
        logic [TICKET_BITS-1:0]   tickets;
        logic [DURATION_BITS-1:0] remaining;
        logic [STRIDE_BITS-1:0]   stride;
        logic [PASS_BITS-1:0]     pass;
    } entry_t;

    localparam int ENTRY_WIDTH = $bits(entry_t);

    // Divider request and response.
    typedef struct packed {
        logic                   start;
        logic [DIV_BITS-1:0]    dividend;
        logic [TICKET_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic [DIV_BITS-1:0]    quotient;
        logic [TICKET_BITS-1:0] remainder;
    } div_resp_t;

endpackage

FILE: design/stride_slice_scheduler.sv
// ============================================================================
// stride_slice_scheduler
// The table of entries (tickets, remaining time, stride, pass) lives in one
// synchronous RAM; started, done and row-valid flags are flip-flops. A load
// item reads its row, then writes it back before its result. A schedule item
// reads the in-use rows one per cycle while it tracks the lowest pass, then
// writes the chosen row back. A compute item walks the in-use rows through
// the serial divider twice per row (a remainder and the new multiple) with a
// subtractive gcd between them, then sweeps all rows with one division per
// in-use row for its stride. Results wait in an output register, so the next
// item is taken while one is held.
// ============================================================================
module stride_slice_scheduler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  sss_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output sss_pkg::out_item_t                 out_data,
    input  logic                               cfg_we,
    input  logic [sss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sss_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int EB = sss_pkg::ENTRY_BITS;
    localparam int CB = sss_pkg::COUNT_BITS;
    localparam int ME = sss_pkg::MAX_ENTRIES;
    localparam int TB = sss_pkg::TICKET_BITS;
    localparam int DB = sss_pkg::DURATION_BITS;
    localparam int PB = sss_pkg::PASS_BITS;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LD_WR   = 4'd1;
    localparam logic [3:0] S_CM_RD   = 4'd2;
    localparam logic [3:0] S_CM_T    = 4'd3;
    localparam logic [3:0] S_CM_MOD  = 4'd4;
    localparam logic [3:0] S_CM_GCD  = 4'd5;
    localparam logic [3:0] S_CM_DIV  = 4'd6;
    localparam logic [3:0] S_SW_RD   = 4'd7;
    localparam logic [3:0] S_SW_T    = 4'd8;
    localparam logic [3:0] S_SW_DIV  = 4'd9;
    localparam logic [3:0] S_SW_WR   = 4'd10;
    localparam logic [3:0] S_SC_SCAN = 4'd11;
    localparam logic [3:0] S_SC_WR   = 4'd12;
    localparam logic [3:0] S_FIN     = 4'd13;

    localparam logic [sss_pkg::CLOCK_BITS-1:0] CLOCK_MAX = '1;

    logic [3:0]                        state_reg, state_next;
    logic [sss_pkg::SLICE_BITS-1:0]    slice_reg;
    logic [sss_pkg::PCOUNT_BITS-1:0]   pcount_reg;
    logic [sss_pkg::CLOCK_BITS-1:0]    clock_reg, clock_next;
    logic [ME-1:0]                     started_reg, started_next;
    logic [ME-1:0]                     done_reg, done_next;
    logic [ME-1:0]                     valid_reg, valid_next;
    logic [EB-1:0]                     idx_reg, idx_next;
    logic [EB-1:0]                     best_reg, best_next;
    logic                              found_reg, found_next;
    logic [sss_pkg::MULT_BITS-1:0]     mult_reg, mult_next;
    logic [sss_pkg::DIV_BITS-1:0]      prod_reg, prod_next;
    logic [TB-1:0]                     gcd_a_reg, gcd_a_next;
    logic [TB-1:0]                     gcd_b_reg, gcd_b_next;
    sss_pkg::entry_t                   rec_reg, rec_next;
    sss_pkg::out_item_t                res_reg, res_next;
    sss_pkg::out_item_t                out_reg, out_next;
    logic                              out_valid_reg, out_valid_next;

    logic [CB-1:0]                     n_eff;
    logic [ME-1:0]                     use_mask;
    logic                              idx_in_use;
    logic                              idx_last_used;
    logic                              idx_last_row;
    logic                              ram_we;
    logic [EB-1:0]                     ram_waddr;
    logic [EB-1:0]                     ram_raddr;
    sss_pkg::entry_t                   ram_wdata;
    sss_pkg::entry_t                   ram_rdata;
    sss_pkg::entry_t                   rec_view;
    sss_pkg::div_req_t                 div_req;
    sss_pkg::div_resp_t                div_resp;
    logic [sss_pkg::SLICE_BITS-1:0]    slice_eff;
    logic                              rem_gt;
    logic [31:0]                       run_time;
    logic [32:0]                       clock_sum;
    logic [sss_pkg::CLOCK_BITS-1:0]    clock_sat;
    logic [PB:0]                       pass_sum;
    logic [PB-1:0]                     pass_sat;

    // Entry memory.
    sss_ram #(
        .WIDTH (sss_pkg::ENTRY_WIDTH),
        .DEPTH (ME)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared serial divider.
    sss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // Entries in use, with out-of-range counts clamped.
    always_comb
    begin
        if (pcount_reg == '0)
        begin
            n_eff = CB'(1);
        end
        else if (32'(pcount_reg) > ME)
        begin
            n_eff = CB'(ME);
        end
        else
        begin
            n_eff = CB'(pcount_reg);
        end
        for (int i = 0; i < ME; i++)
        begin
            use_mask[i] = CB'(i) < n_eff;
        end
    end

    assign idx_in_use    = CB'(idx_reg) < n_eff;
    assign idx_last_used = CB'(idx_reg) == n_eff - CB'(1);
    assign idx_last_row  = idx_reg == EB'(ME - 1);

    // A row never written since reset reads with zero stride and pass.
    always_comb
    begin
        rec_view = ram_rdata;
        if (!valid_reg[idx_reg])
        begin
            rec_view.stride = '0;
            rec_view.pass   = '0;
        end
    end

    // Read address: the scan runs one row ahead of the data.
    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = (in_data.mode == sss_pkg::MODE_LOAD) ?
                            EB'(in_data.entry_index) : '0;
            end
            S_SC_SCAN: ram_raddr = idx_reg + EB'(1);
            default:   ram_raddr = idx_reg;
        endcase
    end

    // Slice arithmetic for the chosen row.
    always_comb
    begin
        slice_eff = (slice_reg == '0) ? sss_pkg::SLICE_BITS'(1) : slice_reg;
        rem_gt    = 32'(rec_reg.remaining) > 32'(slice_eff);
        run_time  = rem_gt ? 32'(slice_eff) : 32'(rec_reg.remaining);
        clock_sum = 33'(clock_reg) + 33'(run_time);
        clock_sat = (clock_sum > 33'(CLOCK_MAX)) ? CLOCK_MAX : clock_sum[19:0];
        pass_sum  = (PB+1)'(rec_reg.pass) + (PB+1)'(rec_reg.stride);
        pass_sat  = pass_sum[PB] ? {PB{1'b1}} : pass_sum[PB-1:0];
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        started_next   = started_reg;
        done_next      = done_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        mult_next      = mult_reg;
        prod_next      = prod_reg;
        gcd_a_next     = gcd_a_reg;
        gcd_b_next     = gcd_b_reg;
        rec_next       = rec_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = rec_reg;
        div_req        = '0;

        case (state_reg)
            // Take an item and start its work.
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next = '0;
                    idx_next = '0;
                    case (in_data.mode)
                        sss_pkg::MODE_LOAD:
                        begin
                            res_next.chosen = in_data.entry_index;
                            idx_next        = EB'(in_data.entry_index);
                            if (in_data.tickets == '0 || in_data.duration == '0)
                            begin
                                res_next.status = sss_pkg::STATUS_ZERO;
                                state_next      = S_FIN;
                            end
                            else if (32'(in_data.entry_index) < ME)
                            begin
                                rec_next.tickets   = in_data.tickets;
                                rec_next.remaining = in_data.duration;
                                state_next         = S_LD_WR;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                        sss_pkg::MODE_COMPUTE:
                        begin
                            mult_next  = sss_pkg::MULT_BITS'(1);
                            state_next = S_CM_T;
                        end
                        sss_pkg::MODE_SCHEDULE:
                        begin
                            found_next = 1'b0;
                            state_next = S_SC_SCAN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // Load: keep the row's stride and pass, replace the rest.
            S_LD_WR:
            begin
                ram_we              = 1'b1;
                ram_wdata           = rec_view;
                ram_wdata.tickets   = rec_reg.tickets;
                ram_wdata.remaining = rec_reg.remaining;
                valid_next[idx_reg] = 1'b1;
                state_next          = S_FIN;
            end

            S_CM_RD:
            begin
                state_next = S_CM_T;
            end

            // Multiple step: start the remainder of the multiple by the tickets.
            S_CM_T:
            begin
                if (rec_view.tickets == '0)
                begin
                    res_next.status = sss_pkg::STATUS_ZERO;
                    state_next      = S_FIN;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = sss_pkg::DIV_BITS'(mult_reg);
                    div_req.divisor  = rec_view.tickets;
                    prod_next        = sss_pkg::DIV_BITS'(mult_reg)
                                     * sss_pkg::DIV_BITS'(rec_view.tickets);
                    gcd_a_next       = rec_view.tickets;
                    state_next       = S_CM_MOD;
                end
            end

            S_CM_MOD:
            begin
                if (div_resp.done)
                begin
                    gcd_b_next = div_resp.remainder;
                    state_next = S_CM_GCD;
                end
            end

            // Subtractive gcd, then divide the product by it.
            S_CM_GCD:
            begin
                if (gcd_b_reg == '0 || gcd_a_reg == gcd_b_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = prod_reg;
                    div_req.divisor  = gcd_a_reg;
                    state_next       = S_CM_DIV;
                end
                else if (gcd_a_reg > gcd_b_reg)
                begin
                    gcd_a_next = gcd_a_reg - gcd_b_reg;
                end
                else
                begin
                    gcd_b_next = gcd_b_reg - gcd_a_reg;
                end
            end

            S_CM_DIV:
            begin
                if (div_resp.done)
                begin
                    if (div_resp.quotient[sss_pkg::DIV_BITS-1:sss_pkg::MULT_BITS] != '0)
                    begin
                        res_next.status = sss_pkg::STATUS_OVERFLOW;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        mult_next = div_resp.quotient[sss_pkg::MULT_BITS-1:0];
                        if (idx_last_used)
                        begin
                            idx_next   = '0;
                            state_next = S_SW_RD;
                        end
                        else
                        begin
                            idx_next   = idx_reg + EB'(1);
                            state_next = S_CM_RD;
                        end
                    end
                end
            end

            S_SW_RD:
            begin
                state_next = S_SW_T;
            end

            // Restart sweep: new strides for rows in use, passes cleared.
            S_SW_T:
            begin
                rec_next = rec_view;
                if (idx_in_use)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = sss_pkg::DIV_BITS'(mult_reg);
                    div_req.divisor  = rec_view.tickets;
                    state_next       = S_SW_DIV;
                end
                else
                begin
                    state_next = S_SW_WR;
                end
            end

            S_SW_DIV:
            begin
                if (div_resp.done)
                begin
                    rec_next.stride = div_resp.quotient[sss_pkg::STRIDE_BITS-1:0];
                    state_next      = S_SW_WR;
                end
            end

            S_SW_WR:
            begin
                ram_we                = 1'b1;
                ram_wdata.pass        = '0;
                valid_next[idx_reg]   = 1'b1;
                started_next[idx_reg] = 1'b0;
                done_next[idx_reg]    = idx_in_use && rec_reg.remaining == '0;
                if (idx_last_row)
                begin
                    clock_next               = '0;
                    res_next.common_multiple = mult_reg;
                    state_next               = S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + EB'(1);
                    state_next = S_SW_RD;
                end
            end

            // Scan for the unfinished row with the lowest pass.
            S_SC_SCAN:
            begin
                if (!done_reg[idx_reg] && (!found_reg || rec_view.pass < rec_reg.pass))
                begin
                    rec_next   = rec_view;
                    best_next  = idx_reg;
                    found_next = 1'b1;
                end
                if (idx_last_used)
                begin
                    state_next = S_SC_WR;
                end
                else
                begin
                    idx_next = idx_reg + EB'(1);
                end
            end

            // Run the chosen row for one slice and write it back.
            S_SC_WR:
            begin
                res_next.start_time = clock_reg;
                if (!found_reg)
                begin
                    res_next.status   = sss_pkg::STATUS_ALL_DONE;
                    res_next.end_time = clock_reg;
                end
                else
                begin
                    ram_we                 = 1'b1;
                    ram_waddr              = best_reg;
                    ram_wdata.remaining    = rem_gt ?
                        DB'(rec_reg.remaining - DB'(slice_eff)) : '0;
                    ram_wdata.pass         = rem_gt ? pass_sat : rec_reg.pass;
                    valid_next[best_reg]   = 1'b1;
                    started_next[best_reg] = 1'b1;
                    done_next[best_reg]    = !rem_gt;
                    clock_next             = clock_sat;
                    res_next.chosen        = sss_pkg::INDEX_BITS'(best_reg);
                    res_next.first_run     = !started_reg[best_reg];
                    res_next.finished      = !rem_gt;
                    res_next.end_time      = clock_sat;
                end
                state_next = S_FIN;
            end

            // Hand the result to the output register once it is free.
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next          = res_reg;
                    out_next.all_done = &(done_reg | ~use_mask);
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slice_reg     <= sss_pkg::DEFAULT_SLICE;
            pcount_reg    <= sss_pkg::DEFAULT_COUNT;
            clock_reg     <= '0;
            started_reg   <= '0;
            done_reg      <= '0;
            valid_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            started_reg   <= started_next;
            done_reg      <= done_next;
            valid_reg     <= valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sss_pkg::REG_TIME_SLICE:
                    begin
                        slice_reg <= cfg_data[sss_pkg::SLICE_BITS-1:0];
                    end
                    sss_pkg::REG_PROCESS_COUNT:
                    begin
                        pcount_reg <= cfg_data[sss_pkg::PCOUNT_BITS-1:0];
                    end
                    default:
                    begin
                        slice_reg <= slice_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        best_reg  <= best_next;
        mult_reg  <= mult_next;
        prod_reg  <= prod_next;
        gcd_a_reg <= gcd_a_next;
        gcd_b_reg <= gcd_b_next;
        rec_reg   <= rec_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    // The divider is never left running once the item is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_resp.busy)
        else $error("divider busy while idle");

    // The memory is written only in the write-back steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_LD_WR || state_reg == S_SW_WR
                    || state_reg == S_SC_WR))
        else $error("entry memory written outside a write-back step");

    // A new result appears only from the final step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result presented without a final step");

    // The scan stays inside the rows in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SC_SCAN |-> CB'(idx_reg) < n_eff)
        else $error("scan past the rows in use");

endmodule

FILE: design/sss_ram.sv
// ============================================================================
// sss_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module sss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/sss_div.sv
// ============================================================================
// sss_div
// Restoring divider, one quotient bit per cycle, for a ticket-sized divisor.
// ============================================================================
module sss_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sss_pkg::div_req_t  req,
    output sss_pkg::div_resp_t resp
);

    localparam int CNT_BITS = $clog2(sss_pkg::DIV_BITS + 1);

    logic                            busy_reg;
    logic                            done_reg;
    logic [CNT_BITS-1:0]             cnt_reg;
    logic [sss_pkg::DIV_BITS-1:0]    quo_reg;
    logic [sss_pkg::TICKET_BITS-1:0] rem_reg;
    logic [sss_pkg::TICKET_BITS-1:0] dvs_reg;
    logic [sss_pkg::TICKET_BITS:0]   shifted;
    logic                            fits;

    // Bring down the next dividend bit and try the subtraction.
    assign shifted = {rem_reg, quo_reg[sss_pkg::DIV_BITS-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(sss_pkg::DIV_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[sss_pkg::DIV_BITS-2:0], fits};
            rem_reg <= fits ? sss_pkg::TICKET_BITS'(shifted - {1'b0, dvs_reg})
                            : shifted[sss_pkg::TICKET_BITS-1:0];
        end
    end

    assign resp.busy      = busy_reg;
    assign resp.done      = done_reg;
    assign resp.quotient  = quo_reg;
    assign resp.remainder = rem_reg;

endmodule

FILE: tb/stride_slice_scheduler_checker.sv
// ============================================================================
// stride_slice_scheduler_checker
// Watches the item channels and the register port of the stride scheduler.
// It predicts every result and compares each returned item, field by field.
// ============================================================================
module stride_slice_scheduler_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  sss_pkg::in_item_t                  in_data,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  sss_pkg::out_item_t                 out_data,
    input  logic                               cfg_we,
    input  logic [sss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                 errors,
    output int                                 pending
);
    import sss_pkg::*;

    localparam logic [CLOCK_BITS-1:0] CLOCK_LIMIT = '1;
    localparam logic [PASS_BITS-1:0]  PASS_LIMIT  = '1;

    // Shadow copy of the scheduler state.
    logic [TICKET_BITS-1:0]   tickets_q   [MAX_ENTRIES];
    logic [DURATION_BITS-1:0] left_q      [MAX_ENTRIES];
    logic [STRIDE_BITS-1:0]   stride_q    [MAX_ENTRIES];
    logic [PASS_BITS-1:0]     pass_q      [MAX_ENTRIES];
    logic                     started_q   [MAX_ENTRIES];
    logic                     done_q      [MAX_ENTRIES];
    logic [CLOCK_BITS-1:0]    now_q;
    logic [SLICE_BITS-1:0]    slice_q;
    logic [PCOUNT_BITS-1:0]   count_q;

    out_item_t expected_results[$];
    int        result_count;

    assign pending = expected_results.size();

    function automatic longint unsigned common_divisor(longint unsigned a,
                                                       longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic int entries_in_use();
        if (count_q == 0)
            return 1;
        if (count_q > MAX_ENTRIES)
            return MAX_ENTRIES;
        return int'(count_q);
    endfunction

    // Apply one accepted item to the shadow state and form its result.
    function automatic out_item_t schedule_outcome(in_item_t item);
        out_item_t       res;
        int              n;
        int              best;
        int              tally;
        bit              found;
        bit              zero_seen;
        bit              too_big;
        longint unsigned lcm;
        logic [SLICE_BITS-1:0]  slice;
        logic [CLOCK_BITS:0]    sum;
        logic [PASS_BITS:0]     next_pass;
        res = '0;
        n = entries_in_use();
        case (item.mode)
            MODE_LOAD:
            begin
                res.chosen = item.entry_index;
                if (item.tickets == 0 || item.duration == 0)
                    res.status = STATUS_ZERO;
                else
                begin
                    tickets_q[item.entry_index] = item.tickets;
                    left_q[item.entry_index] = item.duration;
                end
            end
            MODE_COMPUTE:
            begin
                lcm = 1;
                zero_seen = 1'b0;
                too_big = 1'b0;
                for (int i = 0; i < n; i++)
                begin
                    if (tickets_q[i] == 0)
                    begin
                        zero_seen = 1'b1;
                        break;
                    end
                    lcm = (lcm / common_divisor(lcm, tickets_q[i])) * tickets_q[i];
                    if (lcm > 64'hFFFF_FFFF)
                    begin
                        too_big = 1'b1;
                        break;
                    end
                end
                if (zero_seen)
                    res.status = STATUS_ZERO;
                else if (too_big)
                    res.status = STATUS_OVERFLOW;
                else
                begin
                    now_q = '0;
                    for (int i = 0; i < MAX_ENTRIES; i++)
                    begin
                        pass_q[i] = '0;
                        started_q[i] = 1'b0;
                        done_q[i] = 1'b0;
                    end
                    for (int i = 0; i < n; i++)
                    begin
                        stride_q[i] = STRIDE_BITS'(lcm / tickets_q[i]);
                        if (left_q[i] == 0)
                            done_q[i] = 1'b1;
                    end
                    res.common_multiple = MULT_BITS'(lcm);
                end
            end
            MODE_SCHEDULE:
            begin
                found = 1'b0;
                best = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (!done_q[i] && (!found || pass_q[i] < pass_q[best]))
                    begin
                        best = i;
                        found = 1'b1;
                    end
                end
                res.start_time = now_q;
                if (!found)
                begin
                    res.status = STATUS_ALL_DONE;
                    res.end_time = now_q;
                end
                else
                begin
                    slice = (slice_q == 0) ? SLICE_BITS'(1) : slice_q;
                    res.chosen = INDEX_BITS'(best);
                    res.first_run = !started_q[best];
                    started_q[best] = 1'b1;
                    if (left_q[best] > slice)
                    begin
                        sum = now_q + slice;
                        left_q[best] = left_q[best] - slice;
                        next_pass = pass_q[best] + stride_q[best];
                        pass_q[best] = next_pass[PASS_BITS] ? PASS_LIMIT
                                                            : next_pass[PASS_BITS-1:0];
                    end
                    else
                    begin
                        sum = now_q + left_q[best];
                        left_q[best] = '0;
                        done_q[best] = 1'b1;
                        res.finished = 1'b1;
                    end
                    now_q = sum[CLOCK_BITS] ? CLOCK_LIMIT : sum[CLOCK_BITS-1:0];
                    res.end_time = now_q;
                end
            end
            default:
            begin
            end
        endcase
        tally = 0;
        for (int i = 0; i < n; i++)
            if (done_q[i])
                tally++;
        res.all_done = (tally >= n);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got,
                                   longint unsigned want);
        $display("mismatch on result %0d: %s is %0h, expected %0h",
                 result_count, what, got, want);
        errors++;
    endtask

    // Predict on accepted items, compare on accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                tickets_q[i] = '0;
                left_q[i] = '0;
                stride_q[i] = '0;
                pass_q[i] = '0;
                started_q[i] = 1'b0;
                done_q[i] = 1'b0;
            end
            now_q = '0;
            slice_q = DEFAULT_SLICE;
            count_q = DEFAULT_COUNT;
            expected_results.delete();
            errors = 0;
            result_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_TIME_SLICE)
                    slice_q = cfg_data;
                else if (cfg_index == REG_PROCESS_COUNT)
                    count_q = cfg_data[PCOUNT_BITS-1:0];
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result item %0h", out_data);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch("status", out_data.status, want.status);
                    if (out_data.chosen !== want.chosen)
                        report_mismatch("chosen", out_data.chosen, want.chosen);
                    if (out_data.start_time !== want.start_time)
                        report_mismatch("start_time", out_data.start_time,
                                        want.start_time);
                    if (out_data.end_time !== want.end_time)
                        report_mismatch("end_time", out_data.end_time, want.end_time);
                    if (out_data.first_run !== want.first_run)
                        report_mismatch("first_run", out_data.first_run,
                                        want.first_run);
                    if (out_data.finished !== want.finished)
                        report_mismatch("finished", out_data.finished, want.finished);
                    if (out_data.all_done !== want.all_done)
                        report_mismatch("all_done", out_data.all_done, want.all_done);
                    if (out_data.common_multiple !== want.common_multiple)
                        report_mismatch("common_multiple", out_data.common_multiple,
                                        want.common_multiple);
                end
                result_count++;
            end
            if (in_valid && !in_stall)
                expected_results.push_back(schedule_outcome(in_data));
        end
    end

endmodule

FILE: tb/stride_slice_scheduler_test.sv
// ============================================================================
// stride_slice_scheduler_test
// Drives load, compute and schedule items into the stride scheduler through
// phases of register settings, with random idling on both channels and one
// long hold-off on the result side. The checker beside the block predicts
// and compares every result; this module gives the verdict.
// ============================================================================
module stride_slice_scheduler_test;
    import sss_pkg::*;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    in_item_t                      in_data = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    out_item_t                     out_data;
    logic                          cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data = '0;
    int                            errors;
    int                            pending;

    int item_count;
    int phase_count;
    int compute_count;
    int cycle_count;
    bit steady_send;
    logic [SLICE_BITS-1:0] slice_now;

    stride_slice_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stride_slice_scheduler_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Offer one item, idling now and then, and hold it until it is taken.
    task automatic send_item(logic [1:0] mode, logic [INDEX_BITS-1:0] idx,
                             logic [TICKET_BITS-1:0] tix,
                             logic [DURATION_BITS-1:0] dur);
        while (!steady_send && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{mode: mode, entry_index: idx, tickets: tix, duration: dur};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        item_count++;
    endtask

    // Registers change only once every result is back and the block is quiet.
    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TIME_SLICE)
            slice_now = value;
    endtask

    // Mostly smooth ticket counts so the common multiple fits; some raw ones.
    function automatic logic [TICKET_BITS-1:0] pick_tickets();
        int t;
        if ($urandom_range(99) < 20)
            return TICKET_BITS'($urandom_range(1023, 1));
        t = 1 << $urandom_range(9);
        case ($urandom_range(3))
            0: t = t * 3;
            1: t = t * 5;
            2: t = t * 7;
            default: t = t;
        endcase
        if (t > 1023)
            t = t / 8;
        return TICKET_BITS'(t);
    endfunction

    function automatic logic [DURATION_BITS-1:0] pick_duration();
        int top;
        if ($urandom_range(99) < 10)
            return DURATION_BITS'($urandom_range(65535, 1));
        top = (slice_now == 0 ? 1 : int'(slice_now)) * 3;
        if (top > 65535)
            top = 65535;
        return DURATION_BITS'($urandom_range(top, 1));
    endfunction

    // Result side: random stalls, one quiet stretch, one long hold-off.
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (cycle_count > 3000 && cycle_count < 3010)
            begin
                hold = 0;
                out_stall <= 1'b1;
                while (hold < 400)
                begin
                    @(posedge clk);
                    hold++;
                end
            end
            else if (cycle_count > 30000 && cycle_count < 60000)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 8);
        end
    end

    initial
    begin
        #100_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int n;
        int shots;
        cycle_count = 0;
        item_count = 0;
        phase_count = 0;
        compute_count = 0;
        steady_send = 1'b0;
        slice_now = DEFAULT_SLICE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fill the whole table with field extremes first.
        send_item(MODE_LOAD, 4'd0, 10'd1023, 16'd65535);
        for (int i = 1; i < MAX_ENTRIES - 1; i++)
            send_item(MODE_LOAD, INDEX_BITS'(i), TICKET_BITS'(1 << (i % 10)),
                      DURATION_BITS'(i * 7));
        send_item(MODE_LOAD, 4'd15, 10'd1, 16'd1);
        send_item(MODE_LOAD, 4'd3, 10'd0, 16'd5);
        send_item(MODE_LOAD, 4'd4, 10'd5, 16'd0);
        send_item(MODE_RESERVED, 4'd15, 10'h3FF, 16'hFFFF);
        send_item(MODE_SCHEDULE, 4'd0, 10'd0, 16'd0);
        send_item(MODE_COMPUTE, 4'd0, 10'd0, 16'd0);
        compute_count++;
        send_item(MODE_SCHEDULE, 4'd0, 10'd0, 16'd0);
        send_item(MODE_SCHEDULE, 4'd0, 10'd0, 16'd0);
        send_item(MODE_SCHEDULE, 4'd0, 10'd0, 16'd0);

        // Random phases: settings, loads, compute, a run of schedules.
        while (item_count < 1600)
        begin
            phase_count++;
            case ($urandom_range(9))
                0: write_register(REG_TIME_SLICE, 16'd1);
                1: write_register(REG_TIME_SLICE, 16'd65535);
                2: write_register(REG_TIME_SLICE, 16'd0);
                default: write_register(REG_TIME_SLICE,
                                        CFG_DATA_BITS'($urandom_range(40, 1)));
            endcase
            case ($urandom_range(9))
                0: n = 16;
                1: n = 0;
                2: n = $urandom_range(31, 17);
                default: n = $urandom_range(8, 1);
            endcase
            write_register(REG_PROCESS_COUNT, CFG_DATA_BITS'(n));
            n = (n == 0) ? 1 : (n > 16 ? 16 : n);
            steady_send = (item_count > 700 && item_count < 1000);
            for (int i = 0; i < n; i++)
                send_item(MODE_LOAD, INDEX_BITS'(i), pick_tickets(), pick_duration());
            send_item(MODE_COMPUTE, INDEX_BITS'($urandom), TICKET_BITS'($urandom),
                      DURATION_BITS'($urandom));
            compute_count++;
            shots = n * 4 + 3;
            if (shots > 70)
                shots = 70;
            for (int k = 0; k < shots; k++)
            begin
                case ($urandom_range(19))
                    0: send_item(MODE_LOAD, INDEX_BITS'($urandom), 10'd0,
                                 DURATION_BITS'($urandom));
                    1: send_item(MODE_LOAD, INDEX_BITS'($urandom), pick_tickets(),
                                 16'd0);
                    2: send_item(MODE_RESERVED, INDEX_BITS'($urandom),
                                 TICKET_BITS'($urandom), DURATION_BITS'($urandom));
                    default: send_item(MODE_SCHEDULE, INDEX_BITS'($urandom),
                                       TICKET_BITS'($urandom),
                                       DURATION_BITS'($urandom));
                endcase
            end
        end

        // Drain and let the block settle before the verdict.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Covered %0d items over %0d register phases with %0d stride setups.",
                 item_count, phase_count, compute_count);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
design/sss_pkg.sv
design/sss_ram.sv
design/sss_div.sv
design/stride_slice_scheduler.sv
tb/stride_slice_scheduler_checker.sv
tb/stride_slice_scheduler_test.sv
